// File: design/gvbp_pkg.sv
// shared types and constants for the gc victim batch picker
`default_nettype none

package gvbp_pkg;

    localparam int CFG_W   = 40;
    localparam int RATIO_W = 9;
    localparam int DATA_W  = 64;
    localparam int ADDR_W  = 6;

    // file state code
    localparam logic [1:0] FS_NORMAL = 2'd1;

    // result kinds
    localparam logic KIND_PICK    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // register indexes
    localparam logic [2:0] REG_MERGE_THR     = 3'd0;
    localparam logic [2:0] REG_TARGET_OUT    = 3'd1;
    localparam logic [2:0] REG_MAX_BATCH     = 3'd2;
    localparam logic [2:0] REG_MIN_BATCH     = 3'd3;
    localparam logic [2:0] REG_DISCARD_RATIO = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0]   RST_MERGE_THR     = 40'd8388608;
    localparam logic [CFG_W-1:0]   RST_TARGET_OUT    = 40'd268435456;
    localparam logic [CFG_W-1:0]   RST_MAX_BATCH     = 40'd1073741824;
    localparam logic [CFG_W-1:0]   RST_MIN_BATCH     = 40'd134217728;
    localparam logic [RATIO_W-1:0] RST_DISCARD_RATIO = 9'd128;

    typedef struct packed {
        logic [CFG_W-1:0]   merge_thr;
        logic [CFG_W-1:0]   target_out;
        logic [CFG_W-1:0]   max_batch;
        logic [CFG_W-1:0]   min_batch;
        logic [RATIO_W-1:0] discard_ratio;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic calc;
        logic decide;
        logic emit_cur;
        logic emit_flush;
        logic stop_check;
        logic verdict;
    } t_cmd;

    typedef struct packed {
        logic cur_pend;
        logic flush_pend;
        logic flush_last;
        logic last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: design/gvbp_cfg.sv
// configuration register bank behind the apb-style port
`default_nettype none

module gvbp_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gvbp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [gvbp_pkg::DATA_W-1:0]   pwdata,
    output logic      [gvbp_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output gvbp_pkg::t_cfg                     o_cfg
);

    gvbp_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign w_idx  = paddr[gvbp_pkg::ADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.merge_thr     <= gvbp_pkg::RST_MERGE_THR;
            r_cfg.target_out    <= gvbp_pkg::RST_TARGET_OUT;
            r_cfg.max_batch     <= gvbp_pkg::RST_MAX_BATCH;
            r_cfg.min_batch     <= gvbp_pkg::RST_MIN_BATCH;
            r_cfg.discard_ratio <= gvbp_pkg::RST_DISCARD_RATIO;
        end else if (w_wr) begin
            case (w_idx)
                gvbp_pkg::REG_MERGE_THR: begin
                    r_cfg.merge_thr <= pwdata[gvbp_pkg::CFG_W-1:0];
                end
                gvbp_pkg::REG_TARGET_OUT: begin
                    r_cfg.target_out <= pwdata[gvbp_pkg::CFG_W-1:0];
                end
                gvbp_pkg::REG_MAX_BATCH: begin
                    r_cfg.max_batch <= pwdata[gvbp_pkg::CFG_W-1:0];
                end
                gvbp_pkg::REG_MIN_BATCH: begin
                    r_cfg.min_batch <= pwdata[gvbp_pkg::CFG_W-1:0];
                end
                gvbp_pkg::REG_DISCARD_RATIO: begin
                    r_cfg.discard_ratio <= pwdata[gvbp_pkg::RATIO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            gvbp_pkg::REG_MERGE_THR: begin
                prdata = gvbp_pkg::DATA_W'(r_cfg.merge_thr);
            end
            gvbp_pkg::REG_TARGET_OUT: begin
                prdata = gvbp_pkg::DATA_W'(r_cfg.target_out);
            end
            gvbp_pkg::REG_MAX_BATCH: begin
                prdata = gvbp_pkg::DATA_W'(r_cfg.max_batch);
            end
            gvbp_pkg::REG_MIN_BATCH: begin
                prdata = gvbp_pkg::DATA_W'(r_cfg.min_batch);
            end
            gvbp_pkg::REG_DISCARD_RATIO: begin
                prdata = gvbp_pkg::DATA_W'(r_cfg.discard_ratio);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/gvbp_ctrl.sv
// controller state machine sequencing one candidate word at a time
`default_nettype none

module gvbp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  gvbp_pkg::t_sts      i_sts,
    output gvbp_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.cur_pend) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_cur = 1'b1;
                        if (!i_sts.flush_pend) begin
                            n_state = S_POST;
                        end
                    end
                end else if (i_sts.flush_pend) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_flush = 1'b1;
                        if (i_sts.flush_last) begin
                            n_state = S_POST;
                        end
                    end
                end else begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (!i_sts.last || i_sts.out_free) begin
                    o_in_ready = 1'b1;
                    if (i_sts.last) begin
                        o_cmd.verdict = 1'b1;
                    end else begin
                        o_cmd.stop_check = 1'b1;
                    end
                    if (i_in_valid) begin
                        o_cmd.load_in = 1'b1;
                        n_state       = S_CALC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/gvbp_dp.sv
// datapath: round sums, cold buffer memory, ratio test and result register
`default_nettype none

module gvbp_dp #(
    parameter int COLD_DEPTH = 16,
    parameter int SIZE_BITS  = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  gvbp_pkg::t_cfg         i_cfg,
    input  gvbp_pkg::t_cmd         i_cmd,
    output gvbp_pkg::t_sts         o_sts,
    input  wire logic [39:0]       i_file_id,
    input  wire logic [1:0]        i_file_status,
    input  wire logic [39:0]       i_size_bytes,
    input  wire logic [39:0]       i_discard_bytes,
    input  wire logic              i_is_cold,
    input  wire logic              i_marked_for_gc,
    input  wire logic              i_last_candidate,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_result_kind,
    output logic [39:0]            o_picked_id,
    output logic                   o_run_gc,
    output logic                   o_continue_next,
    output logic [39:0]            o_batch_bytes,
    output logic                   o_end_of_run
);

    localparam int EW = (SIZE_BITS > 40) ? SIZE_BITS : 40;
    localparam int AW = (COLD_DEPTH > 1) ? $clog2(COLD_DEPTH) : 1;
    localparam int PW = SIZE_BITS + gvbp_pkg::RATIO_W;
    localparam int MW = 40 + SIZE_BITS;
    localparam logic [EW-1:0] CAP40 = EW'({40{1'b1}});

    function automatic logic [SIZE_BITS-1:0] sat_add(input logic [SIZE_BITS-1:0] a,
                                                     input logic [SIZE_BITS-1:0] b);
        logic [SIZE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[SIZE_BITS] ? {SIZE_BITS{1'b1}} : s[SIZE_BITS-1:0];
    endfunction

    function automatic logic [39:0] cap40(input logic [SIZE_BITS-1:0] v);
        logic [EW-1:0] w;
        w = EW'(v);
        cap40 = (w > CAP40) ? {40{1'b1}} : w[39:0];
    endfunction

    // captured word
    logic [39:0]          r_id;
    logic [1:0]           r_status;
    logic [SIZE_BITS-1:0] r_size;
    logic [SIZE_BITS-1:0] r_disc;
    logic                 r_cold;
    logic                 r_marked;
    logic                 r_last;

    // first-stage results
    logic [SIZE_BITS-1:0] r_est;
    logic [PW-1:0]        r_prod;
    logic                 r_small;

    // round state
    logic                 r_stopped;
    logic                 r_finished;
    logic                 r_cont;
    logic                 r_any;
    logic [SIZE_BITS-1:0] r_batch;
    logic [SIZE_BITS-1:0] r_hot;
    logic [SIZE_BITS-1:0] r_cold_sum;
    logic [SIZE_BITS-1:0] r_rem;
    logic [AW-1:0]        r_cnt;

    // per-word sequencing state
    logic                 r_cur_pend;
    logic [AW-1:0]        r_fcnt;
    logic [AW-1:0]        r_fidx;
    logic                 r_stop_chk;
    logic                 r_stop_cold;

    // cold buffer
    logic [MW-1:0]        r_mem [COLD_DEPTH];
    logic [MW-1:0]        r_rd;

    // result register
    logic                 r_o_valid;
    logic                 r_o_kind;
    logic [39:0]          r_o_id;
    logic                 r_o_run;
    logic                 r_o_cont;
    logic [39:0]          r_o_bytes;
    logic                 r_o_eor;

    logic [EW-1:0]        w_size_ext;
    logic [EW-1:0]        w_disc_ext;
    logic                 w_eligible;
    logic                 w_push_ok;
    logic [AW-1:0]        w_cnt_new;
    logic [SIZE_BITS-1:0] w_cold_new;
    logic [SIZE_BITS-1:0] w_hot_new;
    logic [SIZE_BITS-1:0] w_rem_new;
    logic                 w_flush_hit;
    logic                 w_ratio_ok;
    logic                 w_keep;
    logic [SIZE_BITS-1:0] w_rd_size;
    logic [39:0]          w_rd_id;
    logic [SIZE_BITS-1:0] w_add_val;
    logic [SIZE_BITS-1:0] w_batch_new;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_mem_we;
    logic [MW-1:0]        w_mem_wdata;
    logic                 w_flush_pend;
    logic                 w_flush_last;
    logic                 w_out_free;
    logic                 w_stop_hit;
    logic                 w_run;

    assign w_size_ext = EW'(i_size_bytes);
    assign w_disc_ext = EW'(i_discard_bytes);

    assign w_eligible = !r_finished && (r_status == gvbp_pkg::FS_NORMAL);
    assign w_push_ok  = (EW'(r_cold_sum) < EW'(i_cfg.merge_thr))
                        && (({1'b0, r_cnt} + (AW+1)'(1)) < (AW+1)'(COLD_DEPTH));
    assign w_cnt_new  = w_push_ok ? (r_cnt + AW'(1)) : r_cnt;
    assign w_cold_new = sat_add(r_cold_sum, r_est);
    assign w_hot_new  = sat_add(r_hot, r_est);
    assign w_rem_new  = sat_add(r_rem, r_size);
    assign w_flush_hit = EW'(w_cold_new) >= EW'(i_cfg.merge_thr);
    assign w_ratio_ok = {1'b0, r_disc, 8'h00} >= r_prod;
    assign w_keep     = r_small || r_marked || w_ratio_ok;

    assign w_rd_id     = r_rd[MW-1:SIZE_BITS];
    assign w_rd_size   = r_rd[SIZE_BITS-1:0];
    assign w_add_val   = i_cmd.emit_cur ? r_size : w_rd_size;
    assign w_batch_new = sat_add(r_batch, w_add_val);

    assign w_rd_addr   = i_cmd.decide ? '0
                       : (i_cmd.emit_flush ? (r_fidx + AW'(1)) : r_fidx);
    assign w_mem_we    = i_cmd.decide && w_eligible && !r_stopped && r_cold && w_push_ok;
    assign w_mem_wdata = {r_id, r_size};

    assign w_flush_pend = r_fidx < r_fcnt;
    assign w_flush_last = r_fidx == (r_fcnt - AW'(1));
    assign w_out_free   = !r_o_valid || i_out_ready;

    assign w_stop_hit = (r_stop_cold ? (EW'(r_cold_sum) >= EW'(i_cfg.target_out))
                                     : (EW'(r_hot) >= EW'(i_cfg.target_out)))
                        || (EW'(r_batch) >= EW'(i_cfg.max_batch));
    assign w_run      = r_any && (EW'(r_batch) >= EW'(i_cfg.min_batch));

    assign o_sts.cur_pend   = r_cur_pend;
    assign o_sts.flush_pend = w_flush_pend;
    assign o_sts.flush_last = w_flush_last;
    assign o_sts.last       = r_last;
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid     = r_o_valid;
    assign o_result_kind   = r_o_kind;
    assign o_picked_id     = r_o_id;
    assign o_run_gc        = r_o_run;
    assign o_continue_next = r_o_cont;
    assign o_batch_bytes   = r_o_bytes;
    assign o_end_of_run    = r_o_eor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped   <= 1'b0;
            r_finished  <= 1'b0;
            r_cont      <= 1'b0;
            r_any       <= 1'b0;
            r_batch     <= '0;
            r_hot       <= '0;
            r_cold_sum  <= '0;
            r_rem       <= '0;
            r_cnt       <= '0;
            r_cur_pend  <= 1'b0;
            r_fcnt      <= '0;
            r_fidx      <= '0;
            r_stop_chk  <= 1'b0;
            r_stop_cold <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cmd.decide) begin
                r_fidx     <= '0;
                r_cur_pend <= 1'b0;
                r_fcnt     <= '0;
                r_stop_chk <= 1'b0;
                if (w_eligible) begin
                    if (!r_stopped) begin
                        r_stop_chk  <= 1'b1;
                        r_stop_cold <= r_cold;
                        if (r_cold) begin
                            r_cold_sum <= w_cold_new;
                            r_cur_pend <= !w_push_ok;
                            if (w_flush_hit) begin
                                r_fcnt <= w_cnt_new;
                                r_cnt  <= '0;
                            end else begin
                                r_cnt <= w_cnt_new;
                            end
                        end else begin
                            r_cur_pend <= 1'b1;
                            r_hot      <= w_hot_new;
                        end
                    end else if (w_keep) begin
                        r_rem <= w_rem_new;
                        if (EW'(w_rem_new) > EW'(i_cfg.min_batch)) begin
                            r_cont     <= 1'b1;
                            r_finished <= 1'b1;
                        end
                    end else begin
                        r_finished <= 1'b1;
                    end
                end
            end
            if (i_cmd.emit_cur) begin
                r_batch    <= w_batch_new;
                r_any      <= 1'b1;
                r_cur_pend <= 1'b0;
            end
            if (i_cmd.emit_flush) begin
                r_batch <= w_batch_new;
                r_any   <= 1'b1;
                r_fidx  <= r_fidx + AW'(1);
            end
            if (i_cmd.stop_check && r_stop_chk && w_stop_hit) begin
                r_stopped <= 1'b1;
            end
            if (i_cmd.verdict) begin
                r_stopped  <= 1'b0;
                r_finished <= 1'b0;
                r_cont     <= 1'b0;
                r_any      <= 1'b0;
                r_batch    <= '0;
                r_hot      <= '0;
                r_cold_sum <= '0;
                r_rem      <= '0;
                r_cnt      <= '0;
            end
            if (i_cmd.emit_cur || i_cmd.emit_flush || i_cmd.verdict) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_id     <= i_file_id;
            r_status <= i_file_status;
            r_size   <= w_size_ext[SIZE_BITS-1:0];
            r_disc   <= w_disc_ext[SIZE_BITS-1:0];
            r_cold   <= i_is_cold;
            r_marked <= i_marked_for_gc;
            r_last   <= i_last_candidate;
        end
        if (i_cmd.calc) begin
            r_est   <= (r_disc > r_size) ? '0 : (r_size - r_disc);
            r_prod  <= PW'(r_size) * PW'(i_cfg.discard_ratio);
            r_small <= EW'(r_size) <= EW'(i_cfg.merge_thr);
        end
        if (i_cmd.emit_cur) begin
            r_o_kind  <= gvbp_pkg::KIND_PICK;
            r_o_id    <= r_id;
            r_o_run   <= 1'b0;
            r_o_cont  <= 1'b0;
            r_o_bytes <= cap40(w_batch_new);
            r_o_eor   <= !r_last && (r_fcnt == '0);
        end else if (i_cmd.emit_flush) begin
            r_o_kind  <= gvbp_pkg::KIND_PICK;
            r_o_id    <= w_rd_id;
            r_o_run   <= 1'b0;
            r_o_cont  <= 1'b0;
            r_o_bytes <= cap40(w_batch_new);
            r_o_eor   <= !r_last && w_flush_last;
        end else if (i_cmd.verdict) begin
            r_o_kind  <= gvbp_pkg::KIND_VERDICT;
            r_o_id    <= '0;
            r_o_run   <= w_run;
            r_o_cont  <= r_cont;
            r_o_bytes <= cap40(r_batch);
            r_o_eor   <= 1'b1;
        end
    end

    // cold buffer: one write port, registered read with write-first forwarding
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_cnt] <= w_mem_wdata;
        end
        if (w_mem_we && (r_cnt == w_rd_addr)) begin
            r_rd <= w_mem_wdata;
        end else begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/gc_victim_batch_picker_top.sv
// top level of the gc victim batch picker
// a word's first pick is emitted from the emit state, after the calc and decide states; a
// verdict is issued from the post state after the word's last pick, or when it picks nothing
// a new word is taken only in the idle or post state, once every pick of the last word is out;
// the sequencer and the single result register set this, a stalled port holds it
// synchronous active-low reset clears round state and loads default registers
`default_nettype none

module gc_victim_batch_picker_top #(
    parameter int COLD_DEPTH = 16,
    parameter int SIZE_BITS  = 40
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gvbp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [gvbp_pkg::DATA_W-1:0]   pwdata,
    output logic      [gvbp_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [39:0]                   i_file_id,
    input  wire logic [1:0]                    i_file_status,
    input  wire logic [39:0]                   i_size_bytes,
    input  wire logic [39:0]                   i_discard_bytes,
    input  wire logic                          i_is_cold,
    input  wire logic                          i_marked_for_gc,
    input  wire logic                          i_last_candidate,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_result_kind,
    output logic [39:0]                        o_picked_id,
    output logic                               o_run_gc,
    output logic                               o_continue_next,
    output logic [39:0]                        o_batch_bytes,
    output logic                               o_end_of_run
);

    gvbp_pkg::t_cfg w_cfg;
    gvbp_pkg::t_cmd w_cmd;
    gvbp_pkg::t_sts w_sts;

    gvbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gvbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gvbp_dp #(
        .COLD_DEPTH (COLD_DEPTH),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_file_id        (i_file_id),
        .i_file_status    (i_file_status),
        .i_size_bytes     (i_size_bytes),
        .i_discard_bytes  (i_discard_bytes),
        .i_is_cold        (i_is_cold),
        .i_marked_for_gc  (i_marked_for_gc),
        .i_last_candidate (i_last_candidate),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_result_kind    (o_result_kind),
        .o_picked_id      (o_picked_id),
        .o_run_gc         (o_run_gc),
        .o_continue_next  (o_continue_next),
        .o_batch_bytes    (o_batch_bytes),
        .o_end_of_run     (o_end_of_run)
    );

endmodule

`default_nettype wire

// File: design/gvbp_checker.sv
// port-level checker for the gc victim batch picker, bound to the top level
`default_nettype none

module gvbp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_result_kind,
    input wire logic [39:0] o_picked_id,
    input wire logic        o_run_gc,
    input wire logic        o_continue_next,
    input wire logic [39:0] o_batch_bytes,
    input wire logic        o_end_of_run
);

    // result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_result_kind) && $stable(o_picked_id) && $stable(o_batch_bytes)
            && $stable(o_end_of_run))
        else $error("result word changed while stalled");

    // a verdict always closes its word and carries no file
    a_verdict_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == gvbp_pkg::KIND_VERDICT) |->
            o_end_of_run && (o_picked_id == 40'd0))
        else $error("malformed verdict word");

    // a picked file never carries verdict flags
    a_pick_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == gvbp_pkg::KIND_PICK) |->
            !o_run_gc && !o_continue_next)
        else $error("verdict flags set on a picked file");

endmodule

bind gc_victim_batch_picker_top gvbp_checker u_gvbp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_result_kind   (o_result_kind),
    .o_picked_id     (o_picked_id),
    .o_run_gc        (o_run_gc),
    .o_continue_next (o_continue_next),
    .o_batch_bytes   (o_batch_bytes),
    .o_end_of_run    (o_end_of_run)
);

`default_nettype wire

// File: tb/gc_victim_batch_picker_top_test.sv
// self-checking testbench for the gc victim batch picker top level
`timescale 1ns / 100ps

module gc_victim_batch_picker_top_test;

    localparam int COLD_SLOTS = 16;
    localparam int RUN_LIMIT  = 1000000;
    localparam int DRAIN_WAIT = 12;

    localparam logic [1:0] FS_MISSING    = 2'd0;
    localparam logic [1:0] FS_COLLECTING = 2'd2;
    localparam logic [1:0] FS_OTHER      = 2'd3;

    localparam logic [39:0] ALL_ONES = '1;

    typedef struct packed {
        logic [39:0] id;
        logic [1:0]  status;
        logic [39:0] size;
        logic [39:0] disc;
        logic        cold;
        logic        marked;
        logic        last;
    } t_candidate;

    typedef struct packed {
        logic        kind;
        logic [39:0] id;
        logic        run;
        logic        cont;
        logic [39:0] batch;
        logic        eor;
    } t_pick;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [gvbp_pkg::ADDR_W-1:0]   paddr = '0;
    logic [gvbp_pkg::DATA_W-1:0]   pwdata = '0;
    logic [gvbp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [39:0]                   i_file_id = '0;
    logic [1:0]                    i_file_status = '0;
    logic [39:0]                   i_size_bytes = '0;
    logic [39:0]                   i_discard_bytes = '0;
    logic                          i_is_cold = 1'b0;
    logic                          i_marked_for_gc = 1'b0;
    logic                          i_last_candidate = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic                          o_result_kind;
    logic [39:0]                   o_picked_id;
    logic                          o_run_gc;
    logic                          o_continue_next;
    logic [39:0]                   o_batch_bytes;
    logic                          o_end_of_run;

    gc_victim_batch_picker_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_file_id        (i_file_id),
        .i_file_status    (i_file_status),
        .i_size_bytes     (i_size_bytes),
        .i_discard_bytes  (i_discard_bytes),
        .i_is_cold        (i_is_cold),
        .i_marked_for_gc  (i_marked_for_gc),
        .i_last_candidate (i_last_candidate),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_picked_id      (o_picked_id),
        .o_run_gc         (o_run_gc),
        .o_continue_next  (o_continue_next),
        .o_batch_bytes    (o_batch_bytes),
        .o_end_of_run     (o_end_of_run)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // picker state as the block should hold it
    gvbp_pkg::t_cfg cfg;
    logic        round_stopped;
    logic        round_finished;
    logic        round_continue;
    logic [39:0] batch_total;
    logic [39:0] hot_out_total;
    logic [39:0] cold_out_total;
    logic [39:0] remain_total;
    logic [15:0] pick_count;
    logic [39:0] parked_id [COLD_SLOTS];
    logic [39:0] parked_size [COLD_SLOTS];
    logic [4:0]  parked_count;

    t_pick       step_picks[$];
    t_pick       picks_due[$];
    t_pick       head_pick;

    int          mismatches = 0;
    int          cycle_count = 0;
    int          idle_send_pct = 0;
    int          idle_recv_pct = 0;
    int          hold_req = 0;
    int          hold_req_len = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    function automatic logic [39:0] sat_sum(input logic [39:0] a, input logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[40] ? ALL_ONES : s[39:0];
    endfunction

    function automatic logic garbage_share_met(input logic [39:0] disc,
                                               input logic [39:0] size);
        logic [63:0] lhs;
        logic [63:0] rhs;
        lhs = 64'(disc) << 8;
        rhs = 64'(size) * 64'(cfg.discard_ratio);
        return lhs >= rhs;
    endfunction

    function automatic void new_round();
        round_stopped  = 1'b0;
        round_finished = 1'b0;
        round_continue = 1'b0;
        batch_total    = '0;
        hot_out_total  = '0;
        cold_out_total = '0;
        remain_total   = '0;
        pick_count     = '0;
        parked_count   = '0;
    endfunction

    function automatic void add_pick(input logic [39:0] id, input logic [39:0] size);
        t_pick p;
        batch_total = sat_sum(batch_total, size);
        if (pick_count != 16'hFFFF) begin
            pick_count = pick_count + 16'd1;
        end
        p.kind  = gvbp_pkg::KIND_PICK;
        p.id    = id;
        p.run   = 1'b0;
        p.cont  = 1'b0;
        p.batch = batch_total;
        p.eor   = 1'b0;
        step_picks.insert(step_picks.size(), p);
    endfunction

    function automatic void predict_picks(input t_candidate c);
        logic [39:0] est;
        t_pick       v;
        step_picks.delete();
        est = (c.disc > c.size) ? 40'd0 : c.size - c.disc;
        if (!round_finished && c.status == gvbp_pkg::FS_NORMAL) begin
            if (!round_stopped) begin
                if (c.cold) begin
                    if (cold_out_total < cfg.merge_thr && parked_count + 1 < COLD_SLOTS) begin
                        parked_id[parked_count]   = c.id;
                        parked_size[parked_count] = c.size;
                        parked_count              = parked_count + 5'd1;
                    end else begin
                        add_pick(c.id, c.size);
                    end
                    cold_out_total = sat_sum(cold_out_total, est);
                    if (cold_out_total >= cfg.merge_thr) begin
                        for (int i = 0; i < parked_count; i++) begin
                            add_pick(parked_id[i], parked_size[i]);
                        end
                        parked_count = '0;
                    end
                    if (cold_out_total >= cfg.target_out || batch_total >= cfg.max_batch) begin
                        round_stopped = 1'b1;
                    end
                end else begin
                    add_pick(c.id, c.size);
                    hot_out_total = sat_sum(hot_out_total, est);
                    if (batch_total >= cfg.max_batch || hot_out_total >= cfg.target_out) begin
                        round_stopped = 1'b1;
                    end
                end
            end else if (c.size <= cfg.merge_thr || c.marked ||
                         garbage_share_met(c.disc, c.size)) begin
                remain_total = sat_sum(remain_total, c.size);
                if (remain_total > cfg.min_batch) begin
                    round_continue = 1'b1;
                    round_finished = 1'b1;
                end
            end else begin
                round_finished = 1'b1;
            end
        end
        if (c.last) begin
            v.kind  = gvbp_pkg::KIND_VERDICT;
            v.id    = '0;
            v.run   = (pick_count != 0) && (batch_total >= cfg.min_batch);
            v.cont  = round_continue;
            v.batch = batch_total;
            v.eor   = 1'b0;
            step_picks.insert(step_picks.size(), v);
            new_round();
        end
        if (step_picks.size() != 0) begin
            step_picks[step_picks.size() - 1].eor = 1'b1;
        end
        foreach (step_picks[i]) begin
            picks_due.insert(picks_due.size(), step_picks[i]);
        end
    endfunction

    function automatic logic [39:0] rand40();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[39:0];
    endfunction

    function automatic logic [39:0] rand_upto(input logic [39:0] lim);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (lim == ALL_ONES) begin
            return r[39:0];
        end
        return 40'(r % (64'(lim) + 64'd1));
    endfunction

    function automatic t_candidate mk(input logic [39:0] id, input logic [1:0] status,
                                      input logic [39:0] size, input logic [39:0] disc,
                                      input logic cold, input logic marked, input logic last);
        t_candidate c;
        c.id     = id;
        c.status = status;
        c.size   = size;
        c.disc   = disc;
        c.cold   = cold;
        c.marked = marked;
        c.last   = last;
        return c;
    endfunction

    function automatic t_candidate rand_candidate(input logic [39:0] scale, input logic last);
        t_candidate c;
        int         r;
        c.id = rand40();
        if ($urandom_range(99) < 85) begin
            c.status = gvbp_pkg::FS_NORMAL;
        end else begin
            case ($urandom_range(2))
                0: c.status = FS_MISSING;
                1: c.status = FS_COLLECTING;
                default: c.status = FS_OTHER;
            endcase
        end
        r = $urandom_range(99);
        if (r < 40) begin
            c.size = rand_upto(scale >> 1);
        end else if (r < 70) begin
            c.size = rand_upto(scale >> 5);
        end else if (r < 80) begin
            c.size = rand40();
        end else if (r < 90) begin
            c.size = 40'($urandom_range(255));
        end else begin
            c.size = cfg.merge_thr;
        end
        r = $urandom_range(99);
        if (r < 75) begin
            c.disc = rand_upto(c.size);
        end else if (r < 85) begin
            c.disc = c.size;
        end else if (r < 93) begin
            c.disc = rand40();
        end else begin
            c.disc = '0;
        end
        c.cold   = 1'($urandom_range(1));
        c.marked = ($urandom_range(4) == 0);
        c.last   = last;
        return c;
    endfunction

    task automatic send_word(input t_candidate c);
        int gap;
        i_file_id        <= c.id;
        i_file_status    <= c.status;
        i_size_bytes     <= c.size;
        i_discard_bytes  <= c.disc;
        i_is_cold        <= c.cold;
        i_marked_for_gc  <= c.marked;
        i_last_candidate <= c.last;
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_picks(c);
        gap = 0;
        while ($urandom_range(99) < idle_send_pct) begin
            gap++;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (picks_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= gvbp_pkg::ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            gvbp_pkg::REG_MERGE_THR:     cfg.merge_thr     = val[gvbp_pkg::CFG_W-1:0];
            gvbp_pkg::REG_TARGET_OUT:    cfg.target_out    = val[gvbp_pkg::CFG_W-1:0];
            gvbp_pkg::REG_MAX_BATCH:     cfg.max_batch     = val[gvbp_pkg::CFG_W-1:0];
            gvbp_pkg::REG_MIN_BATCH:     cfg.min_batch     = val[gvbp_pkg::CFG_W-1:0];
            gvbp_pkg::REG_DISCARD_RATIO: cfg.discard_ratio = val[gvbp_pkg::RATIO_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [39:0] thr, input logic [39:0] target,
                              input logic [39:0] max_b, input logic [39:0] min_b,
                              input logic [8:0] ratio);
        write_reg(gvbp_pkg::REG_MERGE_THR, 64'(thr));
        write_reg(gvbp_pkg::REG_TARGET_OUT, 64'(target));
        write_reg(gvbp_pkg::REG_MAX_BATCH, 64'(max_b));
        write_reg(gvbp_pkg::REG_MIN_BATCH, 64'(min_b));
        write_reg(gvbp_pkg::REG_DISCARD_RATIO, 64'(ratio));
    endtask

    task automatic random_rounds(input int n_words, input logic [39:0] scale);
        int sent;
        int len;
        sent = 0;
        while (sent < n_words) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
            if (len > n_words - sent) begin
                len = n_words - sent;
            end
            for (int j = 0; j < len; j++) begin
                send_word(rand_candidate(scale, j == len - 1));
                sent++;
            end
        end
        wait_drained();
    endtask

    // skipped states, garbage above size, saturating batch, pass decision at reset settings
    task automatic test_skips_and_saturation();
        send_word(mk(40'd1, FS_MISSING, 40'd100, 40'd0, 1'b0, 1'b0, 1'b0));
        send_word(mk(40'd2, FS_COLLECTING, 40'd100, 40'd0, 1'b0, 1'b1, 1'b0));
        send_word(mk(40'd3, FS_OTHER, 40'd100, 40'd0, 1'b1, 1'b0, 1'b0));
        send_word(mk(ALL_ONES, gvbp_pkg::FS_NORMAL, 40'd5, ALL_ONES, 1'b0, 1'b0, 1'b0));
        send_word(mk(40'd0, gvbp_pkg::FS_NORMAL, ALL_ONES, 40'd0, 1'b0, 1'b0, 1'b0));
        send_word(mk(rand40(), gvbp_pkg::FS_NORMAL, ALL_ONES, ALL_ONES, 1'b1, 1'b0, 1'b0));
        send_word(mk(rand40(), gvbp_pkg::FS_NORMAL, 40'd7, 40'd0, 1'b0, 1'b0, 1'b1));
        wait_drained();
    endtask

    // fill the cold buffer to its free slot, overflow straight to the batch, then release
    task automatic test_cold_buffer_overflow();
        set_config(40'd100, ALL_ONES, ALL_ONES, 40'd0, 9'd256);
        for (int j = 0; j < COLD_SLOTS - 1; j++) begin
            send_word(mk(40'(j + 1), gvbp_pkg::FS_NORMAL, 40'd10, 40'd9, 1'b1, 1'b0, 1'b0));
        end
        send_word(mk(40'hAB_CDEF_0123, gvbp_pkg::FS_NORMAL, 40'd300, 40'd0, 1'b1, 1'b0, 1'b1));
        wait_drained();
    endtask

    // stop on output target, marked file, exact garbage share, file just short of the share
    task automatic test_stop_and_pass_decision();
        set_config(40'd1000, 40'd5000, ALL_ONES, 40'd10000, 9'd256);
        send_word(mk(40'd11, gvbp_pkg::FS_NORMAL, 40'd8000, 40'd2000, 1'b0, 1'b0, 1'b0));
        send_word(mk(40'd12, gvbp_pkg::FS_NORMAL, 40'd4000, 40'd0, 1'b0, 1'b1, 1'b0));
        send_word(mk(40'd13, gvbp_pkg::FS_NORMAL, 40'd2000, 40'd2000, 1'b1, 1'b0, 1'b0));
        send_word(mk(40'd14, gvbp_pkg::FS_NORMAL, 40'd2000, 40'd1999, 1'b0, 1'b0, 1'b1));
        wait_drained();
    endtask

    task automatic test_random_rounds(input int n_words, input int send_pct,
                                      input int recv_pct, input logic [39:0] scale);
        idle_send_pct = send_pct;
        idle_recv_pct = recv_pct;
        set_config(rand_upto(scale >> 2), scale + rand_upto(scale), scale << 2,
                   rand_upto(scale << 1), 9'($urandom_range(256)));
        random_rounds(n_words, scale);
    endtask

    task automatic test_extreme_settings();
        idle_send_pct = 0;
        idle_recv_pct = 0;
        set_config('0, '0, '0, '0, 9'd0);
        random_rounds(25, 40'd1 << 20);
        set_config(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 9'd256);
        random_rounds(25, 40'd1 << 38);
    endtask

    // receiver holds off while words keep coming, so the block backs up
    task automatic test_output_backpressure();
        idle_send_pct = 0;
        idle_recv_pct = 0;
        set_config(40'd1 << 20, 40'd1 << 26, 40'd1 << 27, 40'd1 << 24, 9'd128);
        hold_req_len <= 400;
        hold_req     <= hold_req + 1;
        random_rounds(40, 40'd1 << 24);
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= hold_req_len;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= idle_recv_pct);
        end
    end

    task automatic check_field(input string what, input logic [39:0] want,
                               input logic [39:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (picks_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual kind %b id %h",
                         $time, o_result_kind, o_picked_id);
            end else begin
                head_pick = picks_due.pop_front();
                check_field("result_kind", 40'(head_pick.kind), 40'(o_result_kind));
                check_field("picked_id", head_pick.id, o_picked_id);
                check_field("run_gc", 40'(head_pick.run), 40'(o_run_gc));
                check_field("continue_next", 40'(head_pick.cont), 40'(o_continue_next));
                check_field("batch_bytes", head_pick.batch, o_batch_bytes);
                check_field("end_of_run", 40'(head_pick.eor), 40'(o_end_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("gc_victim_batch_picker_top_test failed");
            $finish;
        end
    end

    initial begin
        cfg.merge_thr     = gvbp_pkg::RST_MERGE_THR;
        cfg.target_out    = gvbp_pkg::RST_TARGET_OUT;
        cfg.max_batch     = gvbp_pkg::RST_MAX_BATCH;
        cfg.min_batch     = gvbp_pkg::RST_MIN_BATCH;
        cfg.discard_ratio = gvbp_pkg::RST_DISCARD_RATIO;
        new_round();
        idle_send_pct = 23;
        idle_recv_pct = 77;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_skips_and_saturation();
        test_cold_buffer_overflow();
        test_stop_and_pass_decision();
        test_random_rounds(50, 23, 77, 40'd1 << 20);
        test_random_rounds(50, 23, 77, 40'd1 << 30);
        test_random_rounds(50, 77, 23, 40'd1 << 14);
        test_random_rounds(50, 77, 23, 40'd1 << 36);
        test_random_rounds(50, 0, 0, 40'd1 << 24);
        test_random_rounds(50, 0, 0, 40'd1 << 10);
        test_extreme_settings();
        test_output_backpressure();

        if (mismatches == 0 && picks_due.size() == 0) begin
            $display("gc_victim_batch_picker_top_test passed");
        end else begin
            $display("gc_victim_batch_picker_top_test failed");
        end
        $finish;
    end

endmodule
